### src/qrm_pkg.sv
// Shared types and constants of the qubit register measure block.
package qrm_pkg;

    localparam int QUBITS_DEF   = 10;
    localparam int AMP_BITS_DEF = 16;
    localparam int SUM_W        = 64;
    localparam int ROOT_W       = 32;
    localparam logic [16:0] PROB_MAX = 17'h1FFFF;

    typedef enum logic [1:0] {
        ACT_WRITE   = 2'd0,
        ACT_READ    = 2'd1,
        ACT_SET     = 2'd2,
        ACT_MEASURE = 2'd3
    } action_t;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_DECODE,
        ST_CLEAR,
        ST_MEAS,
        ST_DRAIN,
        ST_SQRT,
        ST_COL_RD,
        ST_COL_LOAD,
        ST_COL_DIV,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic take;
        logic cnt_clr;
        logic cnt_inc;
        logic clear_wr;
        logic item_wr;
        logic item_rd;
        logic meas_issue;
        logic sqrt_load;
        logic sqrt_step;
        logic col_rd;
        logic col_zero;
        logic div_load;
        logic col_wr;
        logic out_load;
    } qrm_cmd_t;

    typedef struct packed {
        action_t action;
        logic    idx_ok;
        logic    field_err;
        logic    collapse;
        logic    cnt_last;
        logic    pipe_idle;
        logic    sqrt_done;
        logic    col_match;
        logic    div_busy;
        logic    out_free;
    } qrm_stat_t;

endpackage

### src/qrm_div.sv
// Restoring divider, one quotient bit per cycle.
module qrm_div #(
    parameter int NUM_W = 32,
    parameter int DEN_W = 32
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             load,
    input  logic [NUM_W-1:0] numer,
    input  logic [DEN_W-1:0] denom,
    output logic             busy,
    output logic [NUM_W-1:0] quotient
);
    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [DEN_W:0]   rem_reg, rem_next, rem_sh;
    logic [NUM_W-1:0] quo_reg, quo_next;
    logic [DEN_W-1:0] den_reg;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    always_comb
    begin
        rem_sh   = {rem_reg[DEN_W-1:0], quo_reg[NUM_W-1]};
        rem_next = rem_reg;
        quo_next = quo_reg;
        cnt_next = cnt_reg;
        if (load)
        begin
            rem_next = '0;
            quo_next = numer;
            cnt_next = CNT_W'(NUM_W);
        end
        else if (cnt_reg != '0)
        begin
            cnt_next = cnt_reg - 1'b1;
            if (rem_sh >= {1'b0, den_reg})
            begin
                rem_next = rem_sh - {1'b0, den_reg};
                quo_next = {quo_reg[NUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = rem_sh;
                quo_next = {quo_reg[NUM_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        if (load)
            den_reg <= denom;
    end

    assign busy     = (cnt_reg != '0);
    assign quotient = quo_reg;

endmodule

### src/qrm_datapath.sv
// Datapath: amplitude memory, binning pipeline, square root and renormalization.
module qrm_datapath #(
    parameter int QUBITS   = 10,
    parameter int AMP_BITS = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  qrm_pkg::qrm_cmd_t   cmd,
    output qrm_pkg::qrm_stat_t  stat,
    input  logic [1:0]          action,
    input  logic [9:0]          index,
    input  logic signed [15:0]  amp_re,
    input  logic signed [15:0]  amp_im,
    input  logic [3:0]          field_start,
    input  logic [3:0]          field_len,
    input  logic                collapse,
    input  logic                out_ready,
    output logic                out_valid,
    output logic signed [15:0]  read_re,
    output logic signed [15:0]  read_im,
    output logic [9:0]          outcome,
    output logic [16:0]         probability,
    output logic                error
);
    import qrm_pkg::*;

    localparam int NSTATES = 1 << QUBITS;
    localparam int FRAC    = AMP_BITS - 2;
    localparam int PR_W    = 2 * AMP_BITS;
    localparam int NUM_W   = ((2 * AMP_BITS - 2) > 31 ? (2 * AMP_BITS - 2) : 31) + 1;
    localparam int BIN_SH  = 2 * FRAC - 16;
    localparam int SHR     = BIN_SH >= 0 ? BIN_SH : 0;
    localparam int SHL     = BIN_SH < 0 ? -BIN_SH : 0;

    function automatic logic [QUBITS-1:0] low_ones(input logic [4:0] n);
        return ~({QUBITS{1'b1}} << n);
    endfunction

    function automatic logic [16:0] to_bin(input logic [SUM_W-1:0] s);
        logic [SUM_W-1:0] v;
        if (SHL > 0 && s > (SUM_W'(PROB_MAX) >> SHL))
            return PROB_MAX;
        v = (s >> SHR) << SHL;
        return (v > SUM_W'(PROB_MAX)) ? PROB_MAX : v[16:0];
    endfunction

    function automatic logic [AMP_BITS-1:0] sat_q(input logic [NUM_W-1:0] q, input logic neg);
        logic [NUM_W-1:0] lim, qs;
        lim = neg ? (NUM_W'(1) << (AMP_BITS - 1)) : ((NUM_W'(1) << (AMP_BITS - 1)) - 1'b1);
        qs  = (q > lim) ? lim : q;
        return neg ? (~qs[AMP_BITS-1:0] + 1'b1) : qs[AMP_BITS-1:0];
    endfunction

    // item registers
    action_t            act_reg;
    logic [9:0]         idx_reg;
    logic signed [15:0] wre_reg, wim_reg;
    logic [3:0]         start_reg, len_reg;
    logic               coll_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            idx_reg <= '0;
        else if (cmd.take)
            idx_reg <= index;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            act_reg   <= action_t'(action);
            wre_reg   <= amp_re;
            wim_reg   <= amp_im;
            start_reg <= field_start;
            len_reg   <= field_len;
            coll_reg  <= collapse;
        end
    end

    logic              idx_ok, field_err;
    logic [QUBITS-1:0] item_addr;
    logic [4:0]        rest;

    assign idx_ok    = 17'(idx_reg) < 17'(NSTATES);
    assign item_addr = QUBITS'(idx_reg);
    assign field_err = (5'(start_reg) > 5'(QUBITS - 1))
                    || ((5'(len_reg) + 5'(start_reg)) > 5'(QUBITS));
    assign rest      = 5'(QUBITS) - 5'(len_reg);

    // sweep counter
    logic [QUBITS-1:0] cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else if (cmd.cnt_clr)
            cnt_reg <= '0;
        else if (cmd.cnt_inc)
            cnt_reg <= cnt_reg + 1'b1;
    end

    // bin-ordered address: field value in the high counter bits
    logic [QUBITS-1:0] meas_i, meas_j, meas_k;
    logic              meas_first, meas_last;

    assign meas_i     = cnt_reg >> rest;
    assign meas_j     = cnt_reg & low_ones(rest);
    assign meas_k     = (meas_j & low_ones(5'(start_reg)))
                      | (meas_i << start_reg)
                      | ((meas_j >> start_reg) << (5'(start_reg) + 5'(len_reg)));
    assign meas_first = (meas_j == '0);
    assign meas_last  = (meas_j == low_ones(rest));

    // amplitude memory
    logic [2*AMP_BITS-1:0] mem [NSTATES];
    logic [2*AMP_BITS-1:0] rd_reg, wr_data;
    logic [QUBITS-1:0]     wr_addr, rd_addr;
    logic                  wr_en, rd_en;
    logic signed [AMP_BITS-1:0] rd_re, rd_im;
    logic [AMP_BITS-1:0]   mag_re, mag_im, one_val, new_re, new_im;
    logic [NUM_W-1:0]      q_re, q_im;
    logic                  neg_re_reg, neg_im_reg;
    logic [SUM_W-1:0]      sq_n_reg, sq_res_reg, sq_bit_reg;

    assign one_val = AMP_BITS'(1) << FRAC;
    assign new_re  = (sq_res_reg == '0) ? '0 : sat_q(q_re, neg_re_reg);
    assign new_im  = (sq_res_reg == '0) ? '0 : sat_q(q_im, neg_im_reg);

    always_comb
    begin
        wr_en   = 1'b1;
        wr_addr = cnt_reg;
        wr_data = '0;
        priority if (cmd.clear_wr)
            wr_data = (cnt_reg == item_addr) ? {one_val, {AMP_BITS{1'b0}}} : '0;
        else if (cmd.item_wr)
        begin
            wr_addr = item_addr;
            wr_data = {AMP_BITS'(wre_reg), AMP_BITS'(wim_reg)};
        end
        else if (cmd.col_zero)
            wr_data = '0;
        else if (cmd.col_wr)
            wr_data = {new_re, new_im};
        else
            wr_en = 1'b0;
    end

    always_comb
    begin
        rd_en   = cmd.item_rd | cmd.meas_issue | cmd.col_rd;
        rd_addr = cnt_reg;
        priority if (cmd.item_rd)
            rd_addr = item_addr;
        else if (cmd.meas_issue)
            rd_addr = meas_k;
        else
            rd_addr = cnt_reg;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (rd_en)
            rd_reg <= mem[rd_addr];
    end

    assign rd_re  = signed'(rd_reg[2*AMP_BITS-1:AMP_BITS]);
    assign rd_im  = signed'(rd_reg[AMP_BITS-1:0]);
    assign mag_re = rd_re[AMP_BITS-1] ? (~rd_reg[2*AMP_BITS-1:AMP_BITS] + 1'b1)
                                      : rd_reg[2*AMP_BITS-1:AMP_BITS];
    assign mag_im = rd_im[AMP_BITS-1] ? (~rd_reg[AMP_BITS-1:0] + 1'b1) : rd_reg[AMP_BITS-1:0];

    // binning pipeline: read, square, accumulate
    logic              v1_reg, first1_reg, last1_reg;
    logic              v2_reg, first2_reg, last2_reg;
    logic [QUBITS-1:0] i1_reg, i2_reg;
    logic [PR_W-1:0]   pre, pim, pre_reg, pim_reg;
    logic [PR_W:0]     sum_sq;
    logic [SUM_W:0]    tot;
    logic [SUM_W-1:0]  acc_reg, acc_next, base;
    logic [16:0]       bin, best_bin_reg;
    logic [QUBITS-1:0] best_idx_reg;
    logic [SUM_W-1:0]  best_sum_reg;

    assign pre = mag_re * mag_re;
    assign pim = mag_im * mag_im;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= cmd.meas_issue;
            v2_reg <= v1_reg;
        end
    end

    assign sum_sq   = {1'b0, pre_reg} + {1'b0, pim_reg};
    assign base     = first2_reg ? '0 : acc_reg;
    assign tot      = {1'b0, base} + (SUM_W + 1)'(sum_sq);
    assign acc_next = tot[SUM_W] ? '1 : tot[SUM_W-1:0];
    assign bin      = to_bin(acc_next);

    always_ff @(posedge clk)
    begin
        first1_reg <= meas_first;
        last1_reg  <= meas_last;
        i1_reg     <= meas_i;
        first2_reg <= first1_reg;
        last2_reg  <= last1_reg;
        i2_reg     <= i1_reg;
        pre_reg    <= pre;
        pim_reg    <= pim;
        if (v2_reg)
        begin
            acc_reg <= acc_next;
            if (last2_reg && (i2_reg == '0 || bin > best_bin_reg))
            begin
                best_bin_reg <= bin;
                best_idx_reg <= i2_reg;
                best_sum_reg <= acc_next;
            end
        end
    end

    // integer square root, two result bits per step pair
    always_ff @(posedge clk)
    begin
        if (cmd.sqrt_load)
        begin
            sq_n_reg   <= best_sum_reg;
            sq_res_reg <= '0;
            sq_bit_reg <= SUM_W'(1) << (SUM_W - 2);
        end
        else if (cmd.sqrt_step)
        begin
            if (sq_n_reg >= sq_res_reg + sq_bit_reg)
            begin
                sq_n_reg   <= sq_n_reg - (sq_res_reg + sq_bit_reg);
                sq_res_reg <= (sq_res_reg >> 1) + sq_bit_reg;
            end
            else
                sq_res_reg <= sq_res_reg >> 1;
            sq_bit_reg <= sq_bit_reg >> 2;
        end
    end

    // renormalization dividers
    logic [ROOT_W-1:0] root;
    logic [NUM_W-1:0]  numer_re, numer_im;
    logic              busy_re, busy_im;

    assign root     = sq_res_reg[ROOT_W-1:0];
    assign numer_re = (NUM_W'(mag_re) << FRAC) + NUM_W'(root >> 1);
    assign numer_im = (NUM_W'(mag_im) << FRAC) + NUM_W'(root >> 1);

    always_ff @(posedge clk)
    begin
        if (cmd.div_load)
        begin
            neg_re_reg <= rd_re[AMP_BITS-1];
            neg_im_reg <= rd_im[AMP_BITS-1];
        end
    end

    qrm_div #(.NUM_W(NUM_W), .DEN_W(ROOT_W)) u_div_re (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (cmd.div_load),
        .numer    (numer_re),
        .denom    (root),
        .busy     (busy_re),
        .quotient (q_re)
    );

    qrm_div #(.NUM_W(NUM_W), .DEN_W(ROOT_W)) u_div_im (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (cmd.div_load),
        .numer    (numer_im),
        .denom    (root),
        .busy     (busy_im),
        .quotient (q_im)
    );

    // result register
    logic out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.out_load)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            read_re     <= (act_reg == ACT_READ && idx_ok) ? 16'(rd_re) : '0;
            read_im     <= (act_reg == ACT_READ && idx_ok) ? 16'(rd_im) : '0;
            outcome     <= (act_reg == ACT_MEASURE && !field_err) ? 10'(best_idx_reg) : '0;
            probability <= (act_reg == ACT_MEASURE && !field_err) ? best_bin_reg : '0;
            error       <= (act_reg == ACT_SET && !idx_ok)
                        || (act_reg == ACT_MEASURE && field_err);
        end
    end

    assign out_valid = out_valid_reg;

    assign stat.action    = act_reg;
    assign stat.idx_ok    = idx_ok;
    assign stat.field_err = field_err;
    assign stat.collapse  = coll_reg;
    assign stat.cnt_last  = &cnt_reg;
    assign stat.pipe_idle = !v1_reg && !v2_reg;
    assign stat.sqrt_done = (sq_bit_reg == '0);
    assign stat.col_match = ((cnt_reg >> start_reg) & low_ones(5'(len_reg))) == best_idx_reg;
    assign stat.div_busy  = busy_re | busy_im;
    assign stat.out_free  = !out_valid_reg || out_ready;

endmodule

### src/qrm_ctrl.sv
// Controller state machine sequencing the datapath.
module qrm_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  qrm_pkg::qrm_stat_t stat,
    output qrm_pkg::qrm_cmd_t  cmd
);
    import qrm_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_INIT;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_INIT:
                if (stat.cnt_last)
                    state_next = ST_IDLE;
            ST_IDLE:
                if (in_valid)
                    state_next = ST_DECODE;
            ST_DECODE:
                unique case (stat.action)
                    ACT_WRITE, ACT_READ:
                        state_next = ST_DONE;
                    ACT_SET:
                        state_next = stat.idx_ok ? ST_CLEAR : ST_DONE;
                    ACT_MEASURE:
                        state_next = stat.field_err ? ST_DONE : ST_MEAS;
                    default:
                        state_next = ST_DONE;
                endcase
            ST_CLEAR:
                if (stat.cnt_last)
                    state_next = ST_DONE;
            ST_MEAS:
                if (stat.cnt_last)
                    state_next = ST_DRAIN;
            ST_DRAIN:
                if (stat.pipe_idle)
                    state_next = stat.collapse ? ST_SQRT : ST_DONE;
            ST_SQRT:
                if (stat.sqrt_done)
                    state_next = ST_COL_RD;
            ST_COL_RD:
                if (stat.col_match)
                    state_next = ST_COL_LOAD;
                else if (stat.cnt_last)
                    state_next = ST_DONE;
            ST_COL_LOAD:
                state_next = ST_COL_DIV;
            ST_COL_DIV:
                if (!stat.div_busy)
                    state_next = stat.cnt_last ? ST_DONE : ST_COL_RD;
            ST_DONE:
                if (stat.out_free)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            ST_INIT:
            begin
                cmd.clear_wr = 1'b1;
                cmd.cnt_inc  = 1'b1;
            end
            ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.take = in_valid;
            end
            ST_DECODE:
                unique case (stat.action)
                    ACT_WRITE:   cmd.item_wr = stat.idx_ok;
                    ACT_READ:    cmd.item_rd = 1'b1;
                    ACT_SET:     cmd.cnt_clr = stat.idx_ok;
                    ACT_MEASURE: cmd.cnt_clr = !stat.field_err;
                    default:     cmd.cnt_clr = 1'b0;
                endcase
            ST_CLEAR:
            begin
                cmd.clear_wr = 1'b1;
                cmd.cnt_inc  = 1'b1;
            end
            ST_MEAS:
            begin
                cmd.meas_issue = 1'b1;
                cmd.cnt_inc    = 1'b1;
            end
            ST_DRAIN:
                if (stat.pipe_idle && stat.collapse)
                begin
                    cmd.sqrt_load = 1'b1;
                    cmd.cnt_clr   = 1'b1;
                end
            ST_SQRT:
                cmd.sqrt_step = !stat.sqrt_done;
            ST_COL_RD:
                if (stat.col_match)
                    cmd.col_rd = 1'b1;
                else
                begin
                    cmd.col_zero = 1'b1;
                    cmd.cnt_inc  = 1'b1;
                end
            ST_COL_LOAD:
                cmd.div_load = 1'b1;
            ST_COL_DIV:
                if (!stat.div_busy)
                begin
                    cmd.col_wr  = 1'b1;
                    cmd.cnt_inc = 1'b1;
                end
            ST_DONE:
                cmd.out_load = stat.out_free;
            default:
                cmd = '0;
        endcase
    end

endmodule

### src/qubit_register_measure.sv
// Top level of the qubit register measure block.
//
//  channel | handshake            | payload
//  in      | in_valid / in_ready  | action index amp_re amp_im field_start field_len collapse
//  out     | out_valid / out_ready| read_re read_im outcome probability error
//
// Set basis rewrites every memory entry, one memory write per cycle.
// Measure reads every amplitude, one amplitude read per cycle through a 3-stage square/add pipe.
// Collapse adds 32 square root steps, then clears each entry outside the kept bin and rescales
// each kept entry (read, divider load, 32 bit-serial divider steps, write back).
// After reset a pass over all 2^QUBITS entries loads basis state 0; no item is taken until it ends.
// One item at a time; the result waits in an output register while out_ready is low.
module qubit_register_measure #(
    parameter int QUBITS   = qrm_pkg::QUBITS_DEF,
    parameter int AMP_BITS = qrm_pkg::AMP_BITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         action,
    input  logic [9:0]         index,
    input  logic signed [15:0] amp_re,
    input  logic signed [15:0] amp_im,
    input  logic [3:0]         field_start,
    input  logic [3:0]         field_len,
    input  logic               collapse,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [15:0] read_re,
    output logic signed [15:0] read_im,
    output logic [9:0]         outcome,
    output logic [16:0]        probability,
    output logic               error
);
    import qrm_pkg::*;

    qrm_cmd_t  cmd;
    qrm_stat_t stat;

    qrm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    qrm_datapath #(.QUBITS(QUBITS), .AMP_BITS(AMP_BITS)) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .action      (action),
        .index       (index),
        .amp_re      (amp_re),
        .amp_im      (amp_im),
        .field_start (field_start),
        .field_len   (field_len),
        .collapse    (collapse),
        .out_ready   (out_ready),
        .out_valid   (out_valid),
        .read_re     (read_re),
        .read_im     (read_im),
        .outcome     (outcome),
        .probability (probability),
        .error       (error)
    );

endmodule

### tb/sv/qubit_register_measure_tb.sv
// Testbench for qubit_register_measure: directed and random items checked against a predictor.
module qubit_register_measure_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import qrm_pkg::*;

    localparam int NAMP = 1024;
    localparam int FRAC = 14;

    typedef struct {
        logic signed [15:0] rd_re;
        logic signed [15:0] rd_im;
        logic [9:0]         outc;
        logic [16:0]        prob;
        logic               err;
    } result_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic [1:0]         action = ACT_WRITE;
    logic [9:0]         index = '0;
    logic signed [15:0] amp_re = '0;
    logic signed [15:0] amp_im = '0;
    logic [3:0]         field_start = '0;
    logic [3:0]         field_len = '0;
    logic               collapse = 1'b0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic signed [15:0] read_re;
    logic signed [15:0] read_im;
    logic [9:0]         outcome;
    logic [16:0]        probability;
    logic               error;

    logic signed [15:0] state_re [NAMP];
    logic signed [15:0] state_im [NAMP];
    longint unsigned    bin_sum  [NAMP];
    result_t            pending_results [$];
    int                 send_idle_pct;
    int                 recv_idle_pct;
    int                 mismatches = 0;
    int                 item_count = 0;

    qubit_register_measure i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .action      (action),
        .index       (index),
        .amp_re      (amp_re),
        .amp_im      (amp_im),
        .field_start (field_start),
        .field_len   (field_len),
        .collapse    (collapse),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .read_re     (read_re),
        .read_im     (read_im),
        .outcome     (outcome),
        .probability (probability),
        .error       (error)
    );

    always #5 clk = ~clk;

    function automatic longint unsigned mag_sq(logic signed [15:0] re, logic signed [15:0] im);
        longint a;
        longint b;
        a = re;
        b = im;
        if (a < 0) a = -a;
        if (b < 0) b = -b;
        return longint'(a * a + b * b);
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned n);
        longint unsigned res;
        longint unsigned bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > n) bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (n >= res + bitv)
            begin
                n = n - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
                res = res >> 1;
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic logic signed [15:0] rescale(logic signed [15:0] a, longint unsigned r);
        longint unsigned m;
        longint unsigned q;
        longint unsigned lim;
        logic neg;
        neg = a < 0;
        if (r == 0) return '0;
        m = neg ? longint'(-longint'(a)) : longint'(a);
        q = ((m << FRAC) + r / 2) / r;
        lim = neg ? 32768 : 32767;
        if (q > lim) q = lim;
        return neg ? 16'(-longint'(q)) : 16'(q);
    endfunction

    function automatic void clear_to_basis(int idx);
        for (int k = 0; k < NAMP; k++)
        begin
            state_re[k] = '0;
            state_im[k] = '0;
        end
        state_re[idx] = 16'sd16384;
    endfunction

    function automatic void add_expected(result_t r);
        pending_results = {pending_results, r};
    endfunction

    function automatic result_t predict_register(logic [1:0] act, logic [9:0] idx,
            logic signed [15:0] wre, logic signed [15:0] wim, logic [3:0] fs,
            logic [3:0] fl, logic col);
        result_t res;
        int mask;
        int best;
        longint unsigned b;
        longint unsigned bins_best;
        longint unsigned r;
        res = '{default: '0};
        case (act)
            ACT_WRITE:
            begin
                state_re[idx] = wre;
                state_im[idx] = wim;
            end
            ACT_READ:
            begin
                res.rd_re = state_re[idx];
                res.rd_im = state_im[idx];
            end
            ACT_SET: clear_to_basis(idx);
            default:
            begin
                if (fs > 9 || fl > 10 - fs)
                    res.err = 1'b1;
                else
                begin
                    mask = (1 << fl) - 1;
                    for (int k = 0; k < NAMP; k++) bin_sum[k] = 0;
                    for (int k = 0; k < NAMP; k++)
                        bin_sum[(k >> fs) & mask] += mag_sq(state_re[k], state_im[k]);
                    best = 0;
                    bins_best = 0;
                    for (int i = 0; i <= mask; i++)
                    begin
                        b = bin_sum[i] >> 12;
                        if (b > 131071) b = 131071;
                        if (i == 0 || b > bins_best)
                        begin
                            best = i;
                            bins_best = b;
                        end
                    end
                    res.outc = 10'(best);
                    res.prob = 17'(bins_best);
                    if (col)
                    begin
                        r = int_sqrt(bin_sum[best]);
                        for (int k = 0; k < NAMP; k++)
                            if (((k >> fs) & mask) == best)
                            begin
                                state_re[k] = rescale(state_re[k], r);
                                state_im[k] = rescale(state_im[k], r);
                            end
                            else
                            begin
                                state_re[k] = '0;
                                state_im[k] = '0;
                            end
                    end
                end
            end
        endcase
        return res;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d (t=%0t)", what, got, want, $time);
        mismatches++;
    endtask

    task automatic send_item(logic [1:0] act, logic [9:0] idx, logic signed [15:0] wre,
            logic signed [15:0] wim, logic [3:0] fs, logic [3:0] fl, logic col);
        if ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        in_valid    <= 1'b1;
        action      <= act;
        index       <= idx;
        amp_re      <= wre;
        amp_im      <= wim;
        field_start <= fs;
        field_len   <= fl;
        collapse    <= col;
        do @(posedge clk); while (!in_ready);
        add_expected(predict_register(act, idx, wre, wim, fs, fl, col));
        item_count++;
    endtask

    task automatic wait_all_results();
        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
    endtask

    always @(posedge clk)
        out_ready <= ($urandom_range(99) >= recv_idle_pct);

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
                report_mismatch("unexpected item", 1, 0);
            else
            begin
                want = pending_results.pop_front();
                if (read_re !== want.rd_re) report_mismatch("read_re", read_re, want.rd_re);
                if (read_im !== want.rd_im) report_mismatch("read_im", read_im, want.rd_im);
                if (outcome !== want.outc) report_mismatch("outcome", outcome, want.outc);
                if (probability !== want.prob)
                    report_mismatch("probability", probability, want.prob);
                if (error !== want.err) report_mismatch("error", error, want.err);
            end
        end
    end

    task automatic test_directed();
        send_item(ACT_READ, 10'd0, 0, 0, 0, 0, 0);
        send_item(ACT_WRITE, 10'd1023, -16'sd32768, 16'sd32767, 0, 0, 0);
        send_item(ACT_READ, 10'd1023, 0, 0, 0, 0, 0);
        send_item(ACT_MEASURE, 10'd0, 0, 0, 4'd0, 4'd0, 1'b0);
        send_item(ACT_MEASURE, 10'd0, 0, 0, 4'd9, 4'd1, 1'b0);
        send_item(ACT_MEASURE, 10'd0, 0, 0, 4'd10, 4'd0, 1'b1);
        send_item(ACT_MEASURE, 10'd0, 0, 0, 4'd15, 4'd15, 1'b1);
        send_item(ACT_MEASURE, 10'd0, 0, 0, 4'd5, 4'd6, 1'b0);
        send_item(ACT_MEASURE, 10'd0, 0, 0, 4'd0, 4'd10, 1'b0);
        // lowest value wins a tie, then collapse on one kept entry
        send_item(ACT_WRITE, 10'd0, 16'sd3000, -16'sd5, 0, 0, 0);
        send_item(ACT_WRITE, 10'd8, 16'sd100, 16'sd7, 0, 0, 0);
        send_item(ACT_WRITE, 10'd1023, 16'sd3000, -16'sd5, 0, 0, 0);
        send_item(ACT_MEASURE, 10'd0, 0, 0, 4'd0, 4'd10, 1'b1);
        send_item(ACT_READ, 10'd0, 0, 0, 0, 0, 0);
        send_item(ACT_SET, 10'd1023, 0, 0, 0, 0, 0);
        send_item(ACT_WRITE, 10'd1023, 16'sd0, 16'sd0, 0, 0, 0);
        // all-zero state: zero probability collapse
        send_item(ACT_MEASURE, 10'd0, 0, 0, 4'd2, 4'd3, 1'b1);
        send_item(ACT_SET, 10'd0, 0, 0, 0, 0, 0);
        send_item(ACT_WRITE, 10'd513, 16'sd9000, -16'sd9000, 0, 0, 0);
        // empty field holds the total, collapse keeps everything
        send_item(ACT_MEASURE, 10'd0, 0, 0, 4'd7, 4'd0, 1'b1);
        send_item(ACT_READ, 10'd513, 0, 0, 0, 0, 0);
        send_item(ACT_READ, 10'd0, 0, 0, 0, 0, 0);
    endtask

    task automatic run_sequence();
        logic [9:0] idx;
        logic [3:0] fs;
        logic [3:0] fl;
        logic col;
        logic signed [15:0] vr;
        logic signed [15:0] vi;
        send_item(ACT_SET, 10'($urandom_range(1023)), 16'($urandom), 16'($urandom), 0, 0, 0);
        repeat ($urandom_range(1, 6))
        begin
            idx = 10'($urandom_range(1023));
            vr = 16'($urandom);
            vi = 16'($urandom);
            if ($urandom_range(3) == 0) vr = $urandom_range(1) ? -16'sd32768 : 16'sd32767;
            if ($urandom_range(2) == 0) vr = vr >>> $urandom_range(2, 8);
            if ($urandom_range(2) == 0) vi = vi >>> $urandom_range(2, 8);
            send_item(ACT_WRITE, idx, vr, vi, 4'($urandom), 4'($urandom), 1'($urandom));
        end
        if ($urandom_range(5) == 0)
        begin
            fs = 4'($urandom);
            fl = 4'($urandom);
        end
        else
        begin
            fs = 4'($urandom_range(9));
            fl = 4'($urandom_range(10 - fs));
        end
        col = 1'($urandom) && fl >= 3;
        send_item(ACT_MEASURE, 10'($urandom), 16'($urandom), 16'($urandom), fs, fl, col);
        repeat ($urandom_range(1, 3))
            send_item(ACT_READ, 10'($urandom_range(1023)), 16'($urandom), 16'($urandom),
                      4'($urandom), 4'($urandom), 1'($urandom));
        if ($urandom_range(3) == 0)
            send_item(ACT_MEASURE, 10'($urandom), 0, 0, 4'($urandom_range(9)), 4'd1, 1'b0);
    endtask

    task automatic test_random();
        int stop_at;
        stop_at = item_count + 38;
        while (item_count < stop_at) run_sequence();
    endtask

    initial
    begin
        clear_to_basis(0);
        send_idle_pct = 19;
        recv_idle_pct = 88;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        test_directed();
        wait_all_results();
        test_random();
        send_idle_pct = 88;
        recv_idle_pct = 19;
        test_random();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random();
        wait_all_results();
        repeat (100) @(posedge clk);
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("FAILURE");
        $finish;
    end

endmodule

### sim.f
src/qrm_pkg.sv
src/qrm_div.sv
src/qrm_datapath.sv
src/qrm_ctrl.sv
src/qubit_register_measure.sv
tb/sv/qubit_register_measure_tb.sv
